### rtl/ljcpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ljcpe_pkg;

  // Number formats.
  localparam int FRAC_BITS  = 16;
  localparam int SUM_WIDTH  = 48;
  localparam int OUT_W      = 48;
  localparam int IN_DW      = 160;
  localparam int OUT_DW     = 104;
  localparam int SCALE_BITS = 19;

  // Arithmetic constants.
  localparam logic [47:0] R2_FLOOR    = 48'd429497;
  localparam logic [31:0] COULOMB_Q24 = 32'd2330950155;
  localparam logic [63:0] SAT_Q24     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ENERGY_CAP  = 64'd1000000 << FRAC_BITS;
  localparam int EN_W  = $clog2(ENERGY_CAP + 64'd1);
  localparam int TOT_W = EN_W + 2;
  localparam int SC_W  = SCALE_BITS + 1;

  // Right shifts applied after each product.
  localparam logic [5:0] SH_Q24   = 6'd24;
  localparam logic [5:0] SH_VDW   = 6'(40 - FRAC_BITS);
  localparam logic [5:0] SH_ELEC  = 6'(56 - FRAC_BITS);
  localparam logic [5:0] SH_SCALE = 6'(SCALE_BITS);

  // Datapath operation codes.
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE  = 5'd0;
  localparam op_t OP_FAULT = 5'd1;
  localparam op_t OP_WRAPX = 5'd2;
  localparam op_t OP_WRAPY = 5'd3;
  localparam op_t OP_WRAPZ = 5'd4;
  localparam op_t OP_SQX   = 5'd5;
  localparam op_t OP_SQY   = 5'd6;
  localparam op_t OP_SQZ   = 5'd7;
  localparam op_t OP_FLOOR = 5'd8;
  localparam op_t OP_DIVS  = 5'd9;
  localparam op_t OP_S2    = 5'd10;
  localparam op_t OP_S3    = 5'd11;
  localparam op_t OP_S6    = 5'd12;
  localparam op_t OP_VM    = 5'd13;
  localparam op_t OP_SQRT  = 5'd14;
  localparam op_t OP_DIVW  = 5'd15;
  localparam op_t OP_EM    = 5'd16;
  localparam op_t OP_DIVSC = 5'd17;
  localparam op_t OP_SCV   = 5'd18;
  localparam op_t OP_SCE   = 5'd19;
  localparam op_t OP_ACC   = 5'd20;
  localparam op_t OP_EMIT  = 5'd21;

  typedef struct packed {
    logic        cutoff_en;
    logic [47:0] cutoff_sq;
    logic        use_pbc;
    logic [22:0] box_x;
    logic [22:0] box_y;
    logic [22:0] box_z;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic go;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic pbc;
    logic fault;
    logic skip;
    logic scale;
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/lj_coulomb_pair_energy_accumulator.sv
// A pair takes longer with periodic wrapping and when the energies are
// rescaled. One pair is taken at a time; the next is not accepted until the
// previous one has finished.
// A result is registered when its last pair finishes and waits in its
// own register while the next pair is taken; a second last pair stalls until it leaves.
// Reset (rst, synchronous) clears the sums, the fault flag and the output valid flag, and resets the config registers.
`timescale 1ns / 1ps
`default_nettype none

module lj_coulomb_pair_energy_accumulator (
  input  wire logic         clk,
  input  wire logic         rst,
  // Pair input: delta_x, delta_y, delta_z, sigma_pair, epsilon_pair,
  // charge_first, charge_second (lowest bits first), zero padded.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [159:0] s_tdata,
  input  wire logic         s_tlast,
  // Totals: vdw_total, elec_total, box_fault (lowest bits first), zero padded.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,
  // Register port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam logic [2:0] REG_CUTOFF_EN = 3'd0;
  localparam logic [2:0] REG_CUTOFF_SQ = 3'd1;
  localparam logic [2:0] REG_USE_PBC   = 3'd2;
  localparam logic [2:0] REG_BOX_X     = 3'd3;
  localparam logic [2:0] REG_BOX_Y     = 3'd4;
  localparam logic [2:0] REG_BOX_Z     = 3'd5;

  ljcpe_pkg::cfg_t cfg;
  ljcpe_pkg::cmd_t cmd;
  ljcpe_pkg::sts_t sts;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; unknown addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_en <= 1'b0;
      cfg.cutoff_sq <= '1;
      cfg.use_pbc   <= 1'b0;
      cfg.box_x     <= '0;
      cfg.box_y     <= '0;
      cfg.box_z     <= '0;
    end else if (wr_en) begin
      case (paddr[5:3])
        REG_CUTOFF_EN: cfg.cutoff_en <= pwdata[0];
        REG_CUTOFF_SQ: cfg.cutoff_sq <= pwdata[47:0];
        REG_USE_PBC:   cfg.use_pbc   <= pwdata[0];
        REG_BOX_X:     cfg.box_x     <= pwdata[22:0];
        REG_BOX_Y:     cfg.box_y     <= pwdata[22:0];
        REG_BOX_Z:     cfg.box_z     <= pwdata[22:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[5:3])
      REG_CUTOFF_EN: prdata = 64'(cfg.cutoff_en);
      REG_CUTOFF_SQ: prdata = 64'(cfg.cutoff_sq);
      REG_USE_PBC:   prdata = 64'(cfg.use_pbc);
      REG_BOX_X:     prdata = 64'(cfg.box_x);
      REG_BOX_Y:     prdata = 64'(cfg.box_y);
      REG_BOX_Z:     prdata = 64'(cfg.box_z);
      default:       prdata = '0;
    endcase
  end

  ljcpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ljcpe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

### rtl/ljcpe_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ljcpe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quo,
  output logic [63:0]      rem
);

  logic [63:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic        ge;
  logic [63:0] rem_next;

  // One shift and trial subtract.
  always_comb begin
    trial    = {rem, quo[63]};
    ge       = trial >= {1'b0, d};
    rem_next = ge ? 64'(trial - {1'b0, d}) : trial[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        d    <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ljcpe_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Bitwise integer square root, two radicand bits per cycle.
module ljcpe_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] t;
  logic        ge;

  always_comb begin
    t  = res + bitv;
    ge = x >= t;
  end

  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= radicand;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x    <= ge ? x - t : x;
        res  <= ge ? (res >> 1) + bitv : res >> 1;
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ljcpe_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// 64x64 multiply from four 32x32 partial products, then shift and saturate.
module ljcpe_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [5:0]  sh,
  input  wire logic [63:0] cap,
  output logic             done,
  output logic [63:0]      res
);

  logic [63:0]  opa;
  logic [63:0]  opb;
  logic [5:0]   shr;
  logic [63:0]  capr;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;
  logic [31:0]  ma;
  logic [31:0]  mb;
  logic [63:0]  prod;
  logic [127:0] addend;
  logic [127:0] shifted;
  logic         over;

  // Partial product selection and alignment of the previous one.
  always_comb begin
    ma     = '0;
    mb     = '0;
    addend = '0;
    case (cnt)
      3'd0: begin
        ma = opa[31:0];
        mb = opb[31:0];
      end
      3'd1: begin
        ma     = opa[31:0];
        mb     = opb[63:32];
        addend = {64'd0, pp};
      end
      3'd2: begin
        ma     = opa[63:32];
        mb     = opb[31:0];
        addend = {32'd0, pp, 32'd0};
      end
      3'd3: begin
        ma     = opa[63:32];
        mb     = opb[63:32];
        addend = {32'd0, pp, 32'd0};
      end
      3'd4: begin
        addend = {pp, 64'd0};
      end
      default: begin
        addend = '0;
      end
    endcase
    prod    = ma * mb;
    shifted = acc >> shr;
    over    = (|shifted[127:64]) || (shifted[63:0] > capr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        opa  <= a;
        opb  <= b;
        shr  <= sh;
        capr <= cap;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        pp  <= prod;
        acc <= acc + addend;
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
          res  <= over ? capr : shifted[63:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ljcpe_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Datapath: pair registers, shared divider, multiplier and root unit, sums.
module ljcpe_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ljcpe_pkg::cmd_t                 cmd,
  input  wire ljcpe_pkg::cfg_t                 cfg,
  input  wire logic [ljcpe_pkg::IN_DW-1:0]     in_data,
  input  wire logic                            in_last,
  output ljcpe_pkg::sts_t                      sts,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ljcpe_pkg::OUT_DW-1:0]         out_data
);

  localparam int SW = ljcpe_pkg::SUM_WIDTH;
  localparam int EW = ljcpe_pkg::EN_W;
  localparam int TW = ljcpe_pkg::TOT_W;

  // Pair registers.
  logic signed [23:0] dx, dy, dz;
  logic [19:0]        sigma;
  logic [23:0]        eps;
  logic signed [19:0] q1, q2;
  logic               last;

  // Intermediate values.
  logic [47:0]              r2;
  logic [39:0]              sig2;
  logic [38:0]              qq;
  logic [63:0]              s, s2, s3, s6, w;
  logic [31:0]              rq;
  logic [EW-1:0]            vm, em;
  logic [ljcpe_pkg::SC_W-1:0] sc;
  logic signed [SW-1:0]     vdw_sum, elec_sum;
  logic                     fault_seen;
  ljcpe_pkg::op_t           pend_op;

  // Output register.
  logic [ljcpe_pkg::OUT_W-1:0] vdw_out, elec_out;
  logic                        fault_out;

  // Unit connections.
  logic        div_go, mul_go, sqrt_go;
  logic [63:0] div_a, div_b, mul_a, mul_b, mul_cap;
  logic [5:0]  mul_sh;
  logic        div_done, mul_done, sqrt_done;
  logic [63:0] div_quo, div_rem, mul_res;
  logic [31:0] sqrt_root;

  // Derived values.
  logic [23:0]          ax, ay, az, asel;
  logic [47:0]          sq;
  logic [19:0]          aq1, aq2;
  logic                 vneg, eneg;
  logic [63:0]          xm;
  logic signed [TW-1:0] vs, es, tot;
  logic [TW-1:0]        tot_mag;
  logic                 box_zero;
  logic [22:0]          wbox;
  logic                 wneg;
  logic [22:0]          wr;
  logic                 half;
  logic signed [24:0]   wv, wres;
  logic signed [SW:0]   vwide, ewide;
  logic signed [SW-1:0] vdw_new, elec_new;

  function automatic logic [23:0] mag24(input logic signed [23:0] v);
    mag24 = v[23] ? 24'(-v) : v;
  endfunction

  function automatic logic [19:0] mag20(input logic signed [19:0] v);
    mag20 = v[19] ? 20'(-v) : v;
  endfunction

  // Saturating add into a running sum.
  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW:0] wide);
    if (wide[SW] != wide[SW-1]) begin
      sat_add = wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_add = wide[SW-1:0];
    end
  endfunction

  // Clamp a running sum to the emitted width.
  function automatic logic [ljcpe_pkg::OUT_W-1:0] out_sat(input logic signed [SW-1:0] v);
    logic [SW-ljcpe_pkg::OUT_W:0] top;
    top = v[SW-1:ljcpe_pkg::OUT_W-1];
    if (top == '0 || top == '1) begin
      out_sat = v[ljcpe_pkg::OUT_W-1:0];
    end else if (v[SW-1]) begin
      out_sat = {1'b1, {(ljcpe_pkg::OUT_W-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(ljcpe_pkg::OUT_W-1){1'b1}}};
    end
  endfunction

  // Magnitudes, signs and the combined energy.
  always_comb begin
    ax       = mag24(dx);
    ay       = mag24(dy);
    az       = mag24(dz);
    aq1      = mag20(q1);
    aq2      = mag20(q2);
    vneg     = s6 < s3;
    eneg     = q1[19] ^ q2[19];
    xm       = vneg ? s3 - s6 : s6 - s3;
    vs       = vneg ? -$signed({2'b00, vm}) : $signed({2'b00, vm});
    es       = eneg ? -$signed({2'b00, em}) : $signed({2'b00, em});
    tot      = vs + es;
    tot_mag  = tot[TW-1] ? TW'(-tot) : tot;
    box_zero = (cfg.box_x == '0) || (cfg.box_y == '0) || (cfg.box_z == '0);
    vwide    = $signed({vdw_sum[SW-1], vdw_sum}) + (SW+1)'(vs);
    ewide    = $signed({elec_sum[SW-1], elec_sum}) + (SW+1)'(es);
    vdw_new  = sat_add(vwide);
    elec_new = sat_add(ewide);
  end

  // Square of one axis, chosen by the operation.
  always_comb begin
    case (cmd.op)
      ljcpe_pkg::OP_SQY: asel = ay;
      ljcpe_pkg::OP_SQZ: asel = az;
      default:           asel = ax;
    endcase
    sq = asel * asel;
  end

  // Minimum image from the remainder of |d| by the box length.
  always_comb begin
    case (pend_op)
      ljcpe_pkg::OP_WRAPY: begin
        wbox = cfg.box_y;
        wneg = dy[23];
      end
      ljcpe_pkg::OP_WRAPZ: begin
        wbox = cfg.box_z;
        wneg = dz[23];
      end
      default: begin
        wbox = cfg.box_x;
        wneg = dx[23];
      end
    endcase
    wr   = div_rem[22:0];
    half = {wr, 1'b0} >= {1'b0, wbox};
    wv   = half ? $signed({2'b00, wr}) - $signed({2'b00, wbox}) : $signed({2'b00, wr});
    wres = wneg ? -wv : wv;
  end

  // Operand selection for the shared units.
  always_comb begin
    div_go  = 1'b0;
    mul_go  = 1'b0;
    sqrt_go = 1'b0;
    div_a   = '0;
    div_b   = '0;
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = ljcpe_pkg::SH_Q24;
    mul_cap = ljcpe_pkg::SAT_Q24;
    case (cmd.op)
      ljcpe_pkg::OP_WRAPX: begin
        div_go = cmd.go;
        div_a  = 64'(ax);
        div_b  = 64'(cfg.box_x);
      end
      ljcpe_pkg::OP_WRAPY: begin
        div_go = cmd.go;
        div_a  = 64'(ay);
        div_b  = 64'(cfg.box_y);
      end
      ljcpe_pkg::OP_WRAPZ: begin
        div_go = cmd.go;
        div_a  = 64'(az);
        div_b  = 64'(cfg.box_z);
      end
      ljcpe_pkg::OP_DIVS: begin
        div_go = cmd.go;
        div_a  = {sig2, 24'd0};
        div_b  = 64'(r2);
      end
      ljcpe_pkg::OP_DIVW: begin
        div_go = cmd.go;
        div_a  = {1'b0, qq, 24'd0};
        div_b  = 64'(rq);
      end
      ljcpe_pkg::OP_DIVSC: begin
        div_go = cmd.go;
        div_a  = ljcpe_pkg::ENERGY_CAP << ljcpe_pkg::SCALE_BITS;
        div_b  = 64'(tot_mag);
      end
      ljcpe_pkg::OP_S2: begin
        mul_go = cmd.go;
        mul_a  = s;
        mul_b  = s;
      end
      ljcpe_pkg::OP_S3: begin
        mul_go = cmd.go;
        mul_a  = s2;
        mul_b  = s;
      end
      ljcpe_pkg::OP_S6: begin
        mul_go = cmd.go;
        mul_a  = s3;
        mul_b  = s3;
      end
      ljcpe_pkg::OP_VM: begin
        mul_go  = cmd.go;
        mul_a   = 64'({eps, 2'b00});
        mul_b   = xm;
        mul_sh  = ljcpe_pkg::SH_VDW;
        mul_cap = ljcpe_pkg::ENERGY_CAP;
      end
      ljcpe_pkg::OP_EM: begin
        mul_go  = cmd.go;
        mul_a   = 64'(ljcpe_pkg::COULOMB_Q24);
        mul_b   = w;
        mul_sh  = ljcpe_pkg::SH_ELEC;
        mul_cap = ljcpe_pkg::ENERGY_CAP;
      end
      ljcpe_pkg::OP_SCV: begin
        mul_go  = cmd.go;
        mul_a   = 64'(vm);
        mul_b   = 64'(sc);
        mul_sh  = ljcpe_pkg::SH_SCALE;
        mul_cap = ljcpe_pkg::ENERGY_CAP;
      end
      ljcpe_pkg::OP_SCE: begin
        mul_go  = cmd.go;
        mul_a   = 64'(em);
        mul_b   = 64'(sc);
        mul_sh  = ljcpe_pkg::SH_SCALE;
        mul_cap = ljcpe_pkg::ENERGY_CAP;
      end
      ljcpe_pkg::OP_SQRT: begin
        sqrt_go = cmd.go;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  ljcpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  ljcpe_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .cap   (mul_cap),
    .done  (mul_done),
    .res   (mul_res)
  );

  ljcpe_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_go),
    .radicand ({r2, 16'd0}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Status back to the controller.
  always_comb begin
    sts.done     = div_done | mul_done | sqrt_done;
    sts.pbc      = cfg.use_pbc;
    sts.fault    = box_zero;
    sts.skip     = cfg.cutoff_en && (r2 > cfg.cutoff_sq);
    sts.scale    = tot_mag > TW'(ljcpe_pkg::ENERGY_CAP);
    sts.last     = last;
    sts.out_free = !out_valid || out_ready;
  end

  // Pair capture and intermediate results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx    <= in_data[23:0];
      dy    <= in_data[47:24];
      dz    <= in_data[71:48];
      sigma <= in_data[91:72];
      eps   <= in_data[115:92];
      q1    <= in_data[135:116];
      q2    <= in_data[155:136];
      last  <= in_last;
    end
    if (cmd.go) begin
      pend_op <= cmd.op;
    end
    case (cmd.go ? cmd.op : ljcpe_pkg::OP_NONE)
      ljcpe_pkg::OP_SQX: r2 <= sq;
      ljcpe_pkg::OP_SQY,
      ljcpe_pkg::OP_SQZ: r2 <= r2 + sq;
      ljcpe_pkg::OP_FLOOR: begin
        if (r2 < ljcpe_pkg::R2_FLOOR) begin
          r2 <= ljcpe_pkg::R2_FLOOR;
        end
        sig2 <= sigma * sigma;
        qq   <= aq1 * aq2;
      end
      default: begin
      end
    endcase
    if (sts.done) begin
      case (pend_op)
        ljcpe_pkg::OP_WRAPX: dx <= wres[23:0];
        ljcpe_pkg::OP_WRAPY: dy <= wres[23:0];
        ljcpe_pkg::OP_WRAPZ: dz <= wres[23:0];
        ljcpe_pkg::OP_DIVS:  s  <= div_quo;
        ljcpe_pkg::OP_DIVW:  w  <= div_quo;
        ljcpe_pkg::OP_DIVSC: sc <= div_quo[ljcpe_pkg::SC_W-1:0];
        ljcpe_pkg::OP_S2:    s2 <= mul_res;
        ljcpe_pkg::OP_S3:    s3 <= mul_res;
        ljcpe_pkg::OP_S6:    s6 <= mul_res;
        ljcpe_pkg::OP_VM,
        ljcpe_pkg::OP_SCV:   vm <= mul_res[EW-1:0];
        ljcpe_pkg::OP_EM,
        ljcpe_pkg::OP_SCE:   em <= mul_res[EW-1:0];
        ljcpe_pkg::OP_SQRT:  rq <= sqrt_root;
        default: begin
        end
      endcase
    end
  end

  // Running sums, fault flag and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vdw_sum    <= '0;
      elec_sum   <= '0;
      fault_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.go && cmd.op == ljcpe_pkg::OP_FAULT) begin
        fault_seen <= 1'b1;
      end
      if (cmd.go && cmd.op == ljcpe_pkg::OP_ACC) begin
        vdw_sum  <= vdw_new;
        elec_sum <= elec_new;
      end
      if (cmd.go && cmd.op == ljcpe_pkg::OP_EMIT) begin
        vdw_out    <= out_sat(vdw_sum);
        elec_out   <= out_sat(elec_sum);
        fault_out  <= fault_seen;
        out_valid  <= 1'b1;
        vdw_sum    <= '0;
        elec_sum   <= '0;
        fault_seen <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = {7'd0, fault_out, elec_out, vdw_out};

endmodule

`default_nettype wire

### rtl/ljcpe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: walks one pair through the datapath operations.
module ljcpe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ljcpe_pkg::sts_t sts,
  output ljcpe_pkg::cmd_t      cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_FAULT = 5'd2;
  localparam logic [4:0] S_WRAPX = 5'd3;
  localparam logic [4:0] S_WRAPY = 5'd4;
  localparam logic [4:0] S_WRAPZ = 5'd5;
  localparam logic [4:0] S_SQX   = 5'd6;
  localparam logic [4:0] S_SQY   = 5'd7;
  localparam logic [4:0] S_SQZ   = 5'd8;
  localparam logic [4:0] S_CHECK = 5'd9;
  localparam logic [4:0] S_FLOOR = 5'd10;
  localparam logic [4:0] S_DIVS  = 5'd11;
  localparam logic [4:0] S_S2    = 5'd12;
  localparam logic [4:0] S_S3    = 5'd13;
  localparam logic [4:0] S_S6    = 5'd14;
  localparam logic [4:0] S_VM    = 5'd15;
  localparam logic [4:0] S_SQRT  = 5'd16;
  localparam logic [4:0] S_DIVW  = 5'd17;
  localparam logic [4:0] S_EM    = 5'd18;
  localparam logic [4:0] S_CHKSC = 5'd19;
  localparam logic [4:0] S_DIVSC = 5'd20;
  localparam logic [4:0] S_SCV   = 5'd21;
  localparam logic [4:0] S_SCE   = 5'd22;
  localparam logic [4:0] S_ACC   = 5'd23;
  localparam logic [4:0] S_FIN   = 5'd24;

  logic [4:0]     state;
  logic [4:0]     state_next;
  logic           pend;
  logic           multi;
  ljcpe_pkg::op_t op;

  // Operation and next state for each step.
  always_comb begin
    op         = ljcpe_pkg::OP_NONE;
    multi      = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.pbc) begin
          state_next = sts.fault ? S_FAULT : S_WRAPX;
        end else begin
          state_next = S_SQX;
        end
      end
      S_FAULT: begin
        op         = ljcpe_pkg::OP_FAULT;
        state_next = S_FIN;
      end
      S_WRAPX: begin
        op    = ljcpe_pkg::OP_WRAPX;
        multi = 1'b1;
        if (sts.done) state_next = S_WRAPY;
      end
      S_WRAPY: begin
        op    = ljcpe_pkg::OP_WRAPY;
        multi = 1'b1;
        if (sts.done) state_next = S_WRAPZ;
      end
      S_WRAPZ: begin
        op    = ljcpe_pkg::OP_WRAPZ;
        multi = 1'b1;
        if (sts.done) state_next = S_SQX;
      end
      S_SQX: begin
        op         = ljcpe_pkg::OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        op         = ljcpe_pkg::OP_SQY;
        state_next = S_SQZ;
      end
      S_SQZ: begin
        op         = ljcpe_pkg::OP_SQZ;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.skip ? S_FIN : S_FLOOR;
      end
      S_FLOOR: begin
        op         = ljcpe_pkg::OP_FLOOR;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        op    = ljcpe_pkg::OP_DIVS;
        multi = 1'b1;
        if (sts.done) state_next = S_S2;
      end
      S_S2: begin
        op    = ljcpe_pkg::OP_S2;
        multi = 1'b1;
        if (sts.done) state_next = S_S3;
      end
      S_S3: begin
        op    = ljcpe_pkg::OP_S3;
        multi = 1'b1;
        if (sts.done) state_next = S_S6;
      end
      S_S6: begin
        op    = ljcpe_pkg::OP_S6;
        multi = 1'b1;
        if (sts.done) state_next = S_VM;
      end
      S_VM: begin
        op    = ljcpe_pkg::OP_VM;
        multi = 1'b1;
        if (sts.done) state_next = S_SQRT;
      end
      S_SQRT: begin
        op    = ljcpe_pkg::OP_SQRT;
        multi = 1'b1;
        if (sts.done) state_next = S_DIVW;
      end
      S_DIVW: begin
        op    = ljcpe_pkg::OP_DIVW;
        multi = 1'b1;
        if (sts.done) state_next = S_EM;
      end
      S_EM: begin
        op    = ljcpe_pkg::OP_EM;
        multi = 1'b1;
        if (sts.done) state_next = S_CHKSC;
      end
      S_CHKSC: begin
        state_next = sts.scale ? S_DIVSC : S_ACC;
      end
      S_DIVSC: begin
        op    = ljcpe_pkg::OP_DIVSC;
        multi = 1'b1;
        if (sts.done) state_next = S_SCV;
      end
      S_SCV: begin
        op    = ljcpe_pkg::OP_SCV;
        multi = 1'b1;
        if (sts.done) state_next = S_SCE;
      end
      S_SCE: begin
        op    = ljcpe_pkg::OP_SCE;
        multi = 1'b1;
        if (sts.done) state_next = S_ACC;
      end
      S_ACC: begin
        op         = ljcpe_pkg::OP_ACC;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          op         = ljcpe_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A multi-cycle step is launched once, then waits for its done pulse.
  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.load = in_valid && in_ready;
    cmd.op   = op;
    cmd.go   = multi ? !pend : (op != ljcpe_pkg::OP_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= multi && !sts.done && (pend || cmd.go);
    end
  end

endmodule

`default_nettype wire
